// File: rtl/dpta_pkg.sv
// Package for the dot-product top-two argmax block.
// Holds the item structs, widths and score limits that the rtl modules share.
// No dependencies.
`timescale 1ns / 1ps

package dpta_pkg;

  localparam int KEY_W   = 24;
  localparam int COL_W   = 10;
  localparam int SCORE_W = 40;
  localparam int PROD_W  = 32;
  localparam int THR_W   = 31;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic [THR_W-1:0]          TIE_RESET = THR_W'(65536);

  typedef struct packed {
    logic signed [KEY_W-1:0] key_part;
    logic signed [KEY_W-1:0] query_part;
    logic [COL_W-1:0]        column_index;
    logic                    last_term;
    logic                    last_column;
  } term_t;

  typedef struct packed {
    logic [COL_W-1:0]          best_index;
    logic [COL_W-1:0]          second_index;
    logic                      tied;
    logic                      skip_row;
    logic signed [SCORE_W-1:0] best_score;
  } result_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic [COL_W-1:0]         column;
    logic                     last_term;
    logic                     last_column;
    logic                     key_nonzero;
  } prod_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] top_score;
    logic [COL_W-1:0]          top_column;
    logic signed [SCORE_W-1:0] runner_score;
    logic [COL_W-1:0]          runner_column;
    logic                      key_seen;
  } snap_t;

endpackage

// File: rtl/dpta_front.sv
// Input register and product stage of the top-two argmax block.
// Registers each item, multiplies key by query and scales to Q16.16.
// Depends on dpta_pkg.
`timescale 1ns / 1ps

module dpta_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           term_valid,
  output logic           term_stall,
  input  dpta_pkg::term_t term,
  output logic           prod_valid,
  input  logic           prod_ready,
  output dpta_pkg::prod_t prod
);
  import dpta_pkg::*;

  logic                      term_reg_valid;
  term_t                     term_reg;
  logic                      s1_free;
  logic                      s2_free;
  logic signed [2*KEY_W-1:0] full_product;

  assign s2_free    = !prod_valid || prod_ready;
  assign s1_free    = !term_reg_valid || s2_free;
  assign term_stall = !s1_free;

  assign full_product = term_reg.key_part * term_reg.query_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_reg_valid <= 1'b0;
      prod_valid     <= 1'b0;
    end else begin
      if (s1_free) begin
        term_reg_valid <= term_valid;
      end
      if (s2_free) begin
        prod_valid <= term_reg_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && term_valid) begin
      term_reg <= term;
    end
    if (s2_free && term_reg_valid) begin
      // floor shift: arithmetic right shift of the Q16.32 product
      prod.product     <= PROD_W'(full_product >>> 16);
      prod.column      <= term_reg.column_index;
      prod.last_term   <= term_reg.last_term;
      prod.last_column <= term_reg.last_column;
      prod.key_nonzero <= (term_reg.key_part != '0);
    end
  end

  property p_prod_hold;
    @(posedge clk) disable iff (rst)
      prod_valid && !prod_ready |=> prod_valid && $stable(prod);
  endproperty
  a_prod_hold: assert property (p_prod_hold) else $error("product item changed while held");

  property p_term_hold;
    @(posedge clk) disable iff (rst)
      term_reg_valid && !s1_free |=> term_reg_valid && $stable(term_reg);
  endproperty
  a_term_hold: assert property (p_term_hold) else $error("input register changed while held");

  property p_stall_when_full;
    @(posedge clk) disable iff (rst)
      term_stall |-> term_reg_valid && prod_valid;
  endproperty
  a_stall_when_full: assert property (p_stall_when_full) else $error("stall with free stage");

endmodule

// File: rtl/dpta_rank.sv
// Score accumulator and running top-two of the argmax block.
// Sums products per column, ranks column scores, snapshots the winners at row end.
// Depends on dpta_pkg.
`timescale 1ns / 1ps

module dpta_rank (
  input  logic            clk,
  input  logic            rst,
  input  logic            prod_valid,
  output logic            prod_ready,
  input  dpta_pkg::prod_t prod,
  output logic            snap_valid,
  input  logic            snap_ready,
  output dpta_pkg::snap_t snap
);
  import dpta_pkg::*;

  logic signed [SCORE_W-1:0] acc;
  logic signed [SCORE_W-1:0] top_score;
  logic signed [SCORE_W-1:0] runner_score;
  logic [COL_W-1:0]          top_column;
  logic [COL_W-1:0]          runner_column;
  logic                      key_seen;

  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W-1:0] score;
  logic signed [SCORE_W-1:0] top_score_next;
  logic signed [SCORE_W-1:0] runner_score_next;
  logic [COL_W-1:0]          top_column_next;
  logic [COL_W-1:0]          runner_column_next;
  logic                      key_seen_next;
  logic                      row_end;
  logic                      fire;

  assign row_end    = prod.last_term && prod.last_column;
  assign prod_ready = !row_end || !snap_valid || snap_ready;
  assign fire       = prod_valid && prod_ready;

  assign sum = {acc[SCORE_W-1], acc} + (SCORE_W+1)'(prod.product);

  always_comb begin
    priority if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      score = sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else begin
      score = sum[SCORE_W-1:0];
    end
  end

  always_comb begin
    top_score_next     = top_score;
    top_column_next    = top_column;
    runner_score_next  = runner_score;
    runner_column_next = runner_column;
    key_seen_next      = key_seen || prod.key_nonzero;
    if (prod.last_term) begin
      priority if (score > top_score) begin
        runner_score_next  = top_score;
        runner_column_next = top_column;
        top_score_next     = score;
        top_column_next    = prod.column;
      end else if (score > runner_score) begin
        runner_score_next  = score;
        runner_column_next = prod.column;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      top_score     <= SCORE_MIN;
      runner_score  <= SCORE_MIN;
      top_column    <= '0;
      runner_column <= '0;
      key_seen      <= 1'b0;
      snap_valid    <= 1'b0;
    end else begin
      if (fire && row_end) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (fire) begin
        if (row_end) begin
          acc           <= '0;
          top_score     <= SCORE_MIN;
          runner_score  <= SCORE_MIN;
          top_column    <= '0;
          runner_column <= '0;
          key_seen      <= 1'b0;
        end else begin
          acc           <= prod.last_term ? '0 : score;
          top_score     <= top_score_next;
          runner_score  <= runner_score_next;
          top_column    <= top_column_next;
          runner_column <= runner_column_next;
          key_seen      <= key_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && row_end) begin
      snap.top_score     <= top_score_next;
      snap.top_column    <= top_column_next;
      snap.runner_score  <= runner_score_next;
      snap.runner_column <= runner_column_next;
      snap.key_seen      <= key_seen_next;
    end
  end

  property p_order;
    @(posedge clk) disable iff (rst)
      top_score >= runner_score;
  endproperty
  a_order: assert property (p_order) else $error("runner-up above top score");

  property p_row_clear;
    @(posedge clk) disable iff (rst)
      fire && row_end |=> acc == '0 && !key_seen && top_score == SCORE_MIN;
  endproperty
  a_row_clear: assert property (p_row_clear) else $error("row state not cleared");

  property p_snap_hold;
    @(posedge clk) disable iff (rst)
      snap_valid && !snap_ready |=> snap_valid && $stable(snap);
  endproperty
  a_snap_hold: assert property (p_snap_hold) else $error("snapshot lost while held");

  property p_col_clear;
    @(posedge clk) disable iff (rst)
      fire && prod.last_term |=> acc == '0;
  endproperty
  a_col_clear: assert property (p_col_clear) else $error("accumulator kept past column end");

endmodule

// File: rtl/dpta_result.sv
// Result stage of the top-two argmax block.
// Applies the tie threshold and skip rule, holds the result item for the consumer.
// Depends on dpta_pkg.
`timescale 1ns / 1ps

module dpta_result (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dpta_pkg::THR_W-1:0] tie_threshold,
  input  logic                       snap_valid,
  output logic                       snap_ready,
  input  dpta_pkg::snap_t            snap,
  output logic                       result_valid,
  input  logic                       result_stall,
  output dpta_pkg::result_t          result
);
  import dpta_pkg::*;

  logic signed [SCORE_W:0] gap;
  logic                    tied_next;

  assign snap_ready = !result_valid || !result_stall;

  assign gap = {snap.top_score[SCORE_W-1], snap.top_score}
             - {snap.runner_score[SCORE_W-1], snap.runner_score};
  assign tied_next = gap < $signed({{(SCORE_W+1-THR_W){1'b0}}, tie_threshold});

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_ready) begin
      result_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      if (snap.key_seen) begin
        result.best_index   <= snap.top_column;
        result.second_index <= snap.runner_column;
        result.tied         <= tied_next;
        result.skip_row     <= 1'b0;
        result.best_score   <= snap.top_score;
      end else begin
        result.best_index   <= '0;
        result.second_index <= '0;
        result.tied         <= 1'b0;
        result.skip_row     <= 1'b1;
        result.best_score   <= '0;
      end
    end
  end

  property p_skip_zero;
    @(posedge clk) disable iff (rst)
      result_valid && result.skip_row |->
        result.best_score == '0 && !result.tied && result.best_index == '0;
  endproperty
  a_skip_zero: assert property (p_skip_zero) else $error("skipped row with nonzero fields");

  property p_take_snap;
    @(posedge clk) disable iff (rst)
      snap_valid && snap_ready |=> result_valid;
  endproperty
  a_take_snap: assert property (p_take_snap) else $error("snapshot taken without result");

  property p_result_hold;
    @(posedge clk) disable iff (rst)
      result_valid && result_stall |=> result_valid && $stable(result);
  endproperty
  a_result_hold: assert property (p_result_hold) else $error("result item changed while held");

endmodule

// File: rtl/dot_product_top2_argmax_core.sv
// Top level of the streaming dot-product top-two argmax block.
// Chains dpta_front, dpta_rank and dpta_result; holds the tie threshold register.
// Depends on dpta_pkg.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-------------------------
//   term     | term_valid    | term_stall    | term   (term_t)
//   result   | result_valid  | result_stall  | result (result_t)
//   config   | cfg_write_enable              | cfg_write_data (31 bits)
//
// One term item per cycle, sustained while no held result stalls the pipe.
// One result item per row, registered after the product and snapshot stages.
// The accumulate and top-two compare loop in dpta_rank, combinational between its registers, sets that rate;
// the multiplier sits alone between the input and product registers.
// rst is synchronous: it clears all stages and the row state, threshold to 1.0.
// A held result stalls the pipe only once every stage holds an item.
`timescale 1ns / 1ps

module dot_product_top2_argmax_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       term_valid,
  output logic                       term_stall,
  input  dpta_pkg::term_t            term,
  output logic                       result_valid,
  input  logic                       result_stall,
  output dpta_pkg::result_t          result,
  input  logic                       cfg_write_enable,
  input  logic [dpta_pkg::THR_W-1:0] cfg_write_data
);
  import dpta_pkg::*;

  logic [THR_W-1:0] tie_threshold;
  logic             prod_valid;
  logic             prod_ready;
  prod_t            prod;
  logic             snap_valid;
  logic             snap_ready;
  snap_t            snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      tie_threshold <= TIE_RESET;
    end else if (cfg_write_enable) begin
      tie_threshold <= cfg_write_data;
    end
  end

  dpta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .term_valid (term_valid),
    .term_stall (term_stall),
    .term       (term),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  dpta_rank u_rank (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  dpta_result u_result (
    .clk           (clk),
    .rst           (rst),
    .tie_threshold (tie_threshold),
    .snap_valid    (snap_valid),
    .snap_ready    (snap_ready),
    .snap          (snap),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for dot_product_top2_argmax_core: streams key/query terms
// with random bursts and result stalls, predicts each row result in a scoreboard class.
// Depends on dpta_pkg and the rtl under rtl/.
`timescale 1ns / 1ps

module testbench;
  import dpta_pkg::*;

  localparam longint SAT_HI = SCORE_MAX;
  localparam longint SAT_LO = SCORE_MIN;

  class argmax_scoreboard;
    longint           threshold;
    longint           col_score;
    longint           top_score;
    longint           runner_score;
    logic [COL_W-1:0] top_col;
    logic [COL_W-1:0] runner_col;
    bit               key_seen;
    result_t          pending_rows[$];
    int               mismatches;

    function new();
      threshold  = longint'(TIE_RESET);
      mismatches = 0;
      clear_row();
    endfunction

    function void clear_row();
      col_score    = 0;
      top_score    = SAT_LO;
      runner_score = SAT_LO;
      top_col      = '0;
      runner_col   = '0;
      key_seen     = 1'b0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] value);
      threshold = longint'(value);
    endfunction

    // advance the row state by one accepted item
    function void accumulate_term(term_t t);
      longint  prod;
      longint  sum;
      longint  kp;
      longint  qp;
      result_t row;
      kp = longint'(t.key_part);
      qp = longint'(t.query_part);
      if (t.key_part != 0) key_seen = 1'b1;
      prod = kp * qp;
      sum  = col_score + (prod >>> 16);
      if (sum > SAT_HI) sum = SAT_HI;
      if (sum < SAT_LO) sum = SAT_LO;
      col_score = sum;
      if (!t.last_term) return;
      if (col_score > top_score) begin
        runner_score = top_score;
        runner_col   = top_col;
        top_score    = col_score;
        top_col      = t.column_index;
      end else if (col_score > runner_score) begin
        runner_score = col_score;
        runner_col   = t.column_index;
      end
      col_score = 0;
      if (!t.last_column) return;
      row = '0;
      if (!key_seen) begin
        row.skip_row = 1'b1;
      end else begin
        row.best_index   = top_col;
        row.second_index = runner_col;
        row.tied         = (top_score - runner_score) < threshold;
        row.best_score   = top_score[SCORE_W-1:0];
      end
      pending_rows.push_back(row);
      clear_row();
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result item: best %0d second %0d tied %0b skip %0b score %0d",
                   $time, got.best_index, got.second_index, got.tied, got.skip_row,
                   got.best_score);
        return;
      end
      want = pending_rows.pop_front();
      if (got.best_index !== want.best_index || got.second_index !== want.second_index ||
          got.tied !== want.tied || got.skip_row !== want.skip_row ||
          got.best_score !== want.best_score) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch: expected best %0d second %0d tied %0b skip %0b score %0d",
                   $time, want.best_index, want.second_index, want.tied, want.skip_row,
                   want.best_score);
          $display("%0t:           got best %0d second %0d tied %0b skip %0b score %0d",
                   $time, got.best_index, got.second_index, got.tied, got.skip_row,
                   got.best_score);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              term_valid = 1'b0;
  logic              term_stall;
  term_t             term = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              cfg_write_enable = 1'b0;
  logic [THR_W-1:0]  cfg_write_data = '0;

  argmax_scoreboard  sb = new();
  int                burst_left = 0;
  int                items_sent = 0;
  int                stall_cycle = 0;

  dot_product_top2_argmax_core dut (
    .clk              (clk),
    .rst              (rst),
    .term_valid       (term_valid),
    .term_stall       (term_stall),
    .term             (term),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  always #5 clk = ~clk;

  // receiver: stall pattern steps through four modes in turn
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 400) % 4)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 1) == 1);
      2: result_stall <= (stall_cycle % 7) < 3;
      default: result_stall <= (stall_cycle % 40) < 25;
    endcase
  end

  function automatic term_t term_of(int k, int q, int col, bit lt, bit lc);
    term_t t;
    t.key_part     = k[KEY_W-1:0];
    t.query_part   = q[KEY_W-1:0];
    t.column_index = col[COL_W-1:0];
    t.last_term    = lt;
    t.last_column  = lc;
    return t;
  endfunction

  function automatic logic signed [KEY_W-1:0] rand_part(int scale);
    int v;
    case (scale)
      0: v = int'($urandom_range(0, 16)) - 8;
      1: v = int'($urandom_range(0, 8192)) - 4096;
      2: v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      default: v = $urandom;
    endcase
    return v[KEY_W-1:0];
  endfunction

  task automatic send_term(term_t t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        term_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    term       <= t;
    term_valid <= 1'b1;
    do @(posedge clk); while (term_stall);
    sb.accumulate_term(t);
    items_sent++;
  endtask

  // wait for every row result, then for the pipe to empty of trailing items
  task automatic drain_rows();
    term_valid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    drain_rows();
    cfg_write_data   <= value;
    cfg_write_enable <= 1'b1;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    sb.set_threshold(value);
  endtask

  task automatic long_column(int k, int q, int col, int n, bit lc);
    for (int i = 0; i < n; i++)
      send_term(term_of(k, q, col, i == n - 1, (i == n - 1) && lc));
  endtask

  task automatic random_row();
    int               n_cols;
    int               n_terms;
    int               scale;
    bit               zero_row;
    bit               lt;
    bit               lc;
    logic [COL_W-1:0] col;
    term_t            t;
    n_cols   = $urandom_range(1, 6);
    scale    = $urandom_range(0, 3);
    zero_row = ($urandom_range(0, 9) == 0);
    col      = COL_W'($urandom_range(0, 1023));
    for (int c = 0; c < n_cols; c++) begin
      if ($urandom_range(0, 3) != 0) col = COL_W'($urandom_range(0, 1023));
      n_terms = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      for (int i = 0; i < n_terms; i++) begin
        lt = (i == n_terms - 1);
        lc = (c == n_cols - 1) && lt;
        if (!lt && $urandom_range(0, 7) == 0) lc = 1'b1;
        t.key_part     = zero_row ? '0 : rand_part(scale);
        t.query_part   = rand_part(scale);
        t.column_index = col;
        t.last_term    = lt;
        t.last_column  = lc;
        send_term(t);
      end
    end
  endtask

  task automatic run_random(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) random_row();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // extremes of both components, both column index ends
    send_term(term_of(8388607, 8388607, 1023, 0, 0));
    send_term(term_of(-8388608, -8388608, 1023, 1, 0));
    send_term(term_of(-8388608, 8388607, 0, 1, 1));
    // all-zero keys skip the row; row mark without column mark is ignored
    send_term(term_of(0, 8388607, 5, 0, 1));
    send_term(term_of(0, -8388608, 5, 1, 0));
    send_term(term_of(0, 1234, 6, 1, 1));
    // single column
    send_term(term_of(65536, 65536, 7, 1, 1));
    // equal scores keep the earlier column, small gap is a tie
    send_term(term_of(65536, 131072, 3, 1, 0));
    send_term(term_of(65536, 131072, 9, 1, 0));
    send_term(term_of(65536, 132072, 4, 1, 1));
    // negative products round toward minus infinity
    send_term(term_of(-1, 1, 2, 1, 0));
    send_term(term_of(1, -1, 8, 1, 0));
    send_term(term_of(0, 5, 1, 1, 1));
    // wide gap
    send_term(term_of(8388607, 8388607, 10, 1, 0));
    send_term(term_of(1, 1, 11, 1, 1));

    // negative saturation to the floor score alone leaves the reset entries standing
    long_column(-8388608, 8388607, 100, 520, 1);
    // positive saturation, then a negative column in the same row
    long_column(-8388608, -8388608, 200, 520, 0);
    long_column(8388607, -8388608, 300, 1, 1);

    run_random(75);
    write_threshold('0);
    run_random(75);
    write_threshold({THR_W{1'b1}});
    run_random(75);
    write_threshold(THR_W'($urandom));
    run_random(75);
    write_threshold(THR_W'($urandom_range(1, 300000)));
    run_random(75);
    write_threshold(TIE_RESET);
    run_random(75);

    drain_rows();
    if (sb.mismatches == 0 && sb.pending_rows.size() == 0) begin
      $display("dot_product_top2_argmax_core test passed");
    end else begin
      $display("dot_product_top2_argmax_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("dot_product_top2_argmax_core test failed");
    $finish;
  end

endmodule
